// ===== hw/rtl/cbrf_pkg.sv =====
package cbrf_pkg;

	// Default geometry of the fixed-point operands.
	localparam int CBRF_X_WIDTH   = 24;
	localparam int CBRF_FRAC_BITS = 16;

	// Tolerance register.
	localparam int                    CBRF_TOL_W     = 23;
	localparam logic [CBRF_TOL_W-1:0] CBRF_TOL_RESET = 23'd33;

	// Pass counter and its hard stop.
	localparam int                    CBRF_CNT_W      = 6;
	localparam logic [CBRF_CNT_W-1:0] CBRF_PASS_LIMIT = 6'd63;

	// Strict sign of the cubic at one point.
	typedef enum logic [1:0] {
		SGN_ZERO = 2'b00,
		SGN_POS  = 2'b01,
		SGN_NEG  = 2'b10
	} cbrf_sign_t;

	// Which bracket point goes to the evaluator.
	typedef enum logic [1:0] {
		SEL_LOW  = 2'b00,
		SEL_HIGH = 2'b01,
		SEL_MID  = 2'b10
	} cbrf_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic      load;
		logic      eval_start;
		cbrf_sel_t eval_sel;
		logic      latch_sign;
		logic      take_mid;
		logic      apply_mid;
		logic      finish_no_root;
		logic      finish_bracket;
		logic      finish_mid_root;
	} cbrf_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic eval_done;
		logic same_sign;
		logic more_passes;
		logic mid_zero;
	} cbrf_status_t;

endpackage

// ===== hw/rtl/cbrf_cubic_eval.sv =====
module cbrf_cubic_eval
	import cbrf_pkg::*;
#(
	parameter int X_WIDTH   = CBRF_X_WIDTH,
	parameter int FRAC_BITS = CBRF_FRAC_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [X_WIDTH-1:0] x,
	output logic                      done,
	output cbrf_sign_t                sign
);

	// Width that holds x^3 - 6x*2^(2F) + 4*2^(3F) exactly, with a sign bit to spare.
	localparam int T1  = 3 * X_WIDTH;
	localparam int T2  = X_WIDTH + 2 * FRAC_BITS + 3;
	localparam int T3  = 3 * FRAC_BITS + 3;
	localparam int T12 = (T1 > T2) ? T1 : T2;
	localparam int FW  = ((T12 > T3) ? T12 : T3) + 2;
	localparam int CW  = 3 * X_WIDTH;
	localparam int PW  = 2 * X_WIDTH;

	typedef enum logic [5:0] {
		EV_IDLE = 6'b000001,
		EV_SQ   = 6'b000010,
		EV_LO   = 6'b000100,
		EV_HI   = 6'b001000,
		EV_ACC  = 6'b010000,
		EV_SUM  = 6'b100000
	} cbrf_ev_state_t;

	cbrf_ev_state_t       step_q;
	logic [X_WIDTH-1:0]   mag_q;
	logic                 neg_q;
	logic [PW-1:0]        prod_q;
	logic [X_WIDTH-1:0]   sq_hi_q;
	logic [CW-1:0]        cube_q;
	logic                 done_q;
	cbrf_sign_t           sign_q;

	logic [X_WIDTH-1:0]   mul_a;
	logic [PW-1:0]        mul_p;
	logic [X_WIDTH+2:0]   six_mag;
	logic [FW-1:0]        cube_w;
	logic [FW-1:0]        lin_w;
	logic [FW-1:0]        const_w;
	logic [FW-1:0]        f_w;
	cbrf_sign_t           f_sign;

	// Shared multiplier: square first, then the two halves of the square times |x|.
	always_comb begin
		case (step_q)
			EV_SQ:   mul_a = mag_q;
			EV_LO:   mul_a = prod_q[X_WIDTH-1:0];
			EV_HI:   mul_a = sq_hi_q;
			default: mul_a = mag_q;
		endcase
	end

	assign mul_p = PW'(mul_a) * PW'(mag_q);

	// Final sum of the three terms and its strict sign.
	always_comb begin
		six_mag = ((X_WIDTH+3)'(mag_q) << 2) + ((X_WIDTH+3)'(mag_q) << 1);
		cube_w  = FW'(cube_q);
		lin_w   = FW'(six_mag) << (2 * FRAC_BITS);
		const_w = FW'(4) << (3 * FRAC_BITS);
		if (neg_q) begin
			f_w = const_w - cube_w + lin_w;
		end else begin
			f_w = const_w + cube_w - lin_w;
		end
		if (f_w[FW-1]) begin
			f_sign = SGN_NEG;
		end else if (f_w == '0) begin
			f_sign = SGN_ZERO;
		end else begin
			f_sign = SGN_POS;
		end
	end

	// Step sequencer and done strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= EV_IDLE;
			done_q <= 1'b0;
			sign_q <= SGN_ZERO;
		end else begin
			done_q <= 1'b0;
			case (step_q)
				EV_IDLE: begin
					if (start) begin
						step_q <= EV_SQ;
					end
				end
				EV_SQ:   step_q <= EV_LO;
				EV_LO:   step_q <= EV_HI;
				EV_HI:   step_q <= EV_ACC;
				EV_ACC:  step_q <= EV_SUM;
				EV_SUM: begin
					step_q <= EV_IDLE;
					done_q <= 1'b1;
					sign_q <= f_sign;
				end
				default: step_q <= EV_IDLE;
			endcase
		end
	end

	// Operand capture, partial products and the cube accumulator.
	always_ff @(posedge clk) begin
		if (start && (step_q == EV_IDLE)) begin
			neg_q <= x[X_WIDTH-1];
			mag_q <= x[X_WIDTH-1] ? X_WIDTH'(-x) : X_WIDTH'(x);
		end
		if (step_q == EV_SQ || step_q == EV_LO || step_q == EV_HI) begin
			prod_q <= mul_p;
		end
		if (step_q == EV_LO) begin
			sq_hi_q <= prod_q[PW-1:X_WIDTH];
		end
		if (step_q == EV_HI) begin
			cube_q <= CW'(prod_q);
		end else if (step_q == EV_ACC) begin
			cube_q <= cube_q + (CW'(prod_q) << X_WIDTH);
		end
	end

	assign done = done_q;
	assign sign = sign_q;

`ifndef ASSERT_OFF
	a_start_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> step_q == EV_IDLE)
		else $error("cubic evaluation started while one is running");
`endif

endmodule

// ===== hw/rtl/cbrf_datapath.sv =====
module cbrf_datapath
	import cbrf_pkg::*;
#(
	parameter int X_WIDTH   = CBRF_X_WIDTH,
	parameter int FRAC_BITS = CBRF_FRAC_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cbrf_cmd_t                 cmd,
	output cbrf_status_t              status,
	input  logic signed [X_WIDTH-1:0] interval_low,
	input  logic signed [X_WIDTH-1:0] interval_high,
	input  logic                      tolerance_wr_en,
	input  logic [CBRF_TOL_W-1:0]     tolerance_wr_data,
	output logic signed [X_WIDTH-1:0] root,
	output logic [CBRF_CNT_W-1:0]     iteration_count,
	output logic                      no_root,
	output logic                      done
);

	// Width for comparing the bracket width against twice the tolerance plus two.
	localparam int DW0 = (X_WIDTH + 1 > CBRF_TOL_W + 2) ? X_WIDTH + 1 : CBRF_TOL_W + 2;
	localparam int DW  = DW0 + 1;

	logic [CBRF_TOL_W-1:0]     tol_q;
	logic signed [X_WIDTH-1:0] low_q;
	logic signed [X_WIDTH-1:0] high_q;
	logic signed [X_WIDTH-1:0] mid_q;
	cbrf_sign_t                low_sign_q;
	cbrf_sign_t                high_sign_q;
	cbrf_sign_t                mid_sign_q;
	logic [CBRF_CNT_W-1:0]     pass_cnt_q;
	logic signed [X_WIDTH-1:0] root_q;
	logic [CBRF_CNT_W-1:0]     count_q;
	logic                      no_root_q;
	logic                      done_q;

	logic signed [X_WIDTH:0]   sum_w;
	logic signed [X_WIDTH-1:0] bracket_mid_w;
	logic signed [DW-1:0]      diff_w;
	logic signed [DW-1:0]      thr_w;
	logic signed [X_WIDTH-1:0] eval_x;
	logic                      eval_done;
	cbrf_sign_t                eval_sign;
	logic                      opposite_w;

	// Floor midpoint of the current bracket.
	assign sum_w         = (X_WIDTH+1)'(low_q) + (X_WIDTH+1)'(high_q);
	assign bracket_mid_w = sum_w[X_WIDTH:1];

	// Loop test: floor((high - low) / 2) > tolerance, i.e. high - low >= 2 * tolerance + 2.
	assign diff_w = DW'(high_q) - DW'(low_q);
	assign thr_w  = $signed(DW'({tol_q, 1'b0}) + DW'(2));

	assign opposite_w = ((low_sign_q == SGN_POS) && (mid_sign_q == SGN_NEG)) ||
	                    ((low_sign_q == SGN_NEG) && (mid_sign_q == SGN_POS));

	// Point handed to the evaluator.
	always_comb begin
		case (cmd.eval_sel)
			SEL_LOW:  eval_x = low_q;
			SEL_HIGH: eval_x = high_q;
			SEL_MID:  eval_x = mid_q;
			default:  eval_x = low_q;
		endcase
	end

	cbrf_cubic_eval #(
		.X_WIDTH   (X_WIDTH),
		.FRAC_BITS (FRAC_BITS)
	) u_eval (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.eval_start),
		.x      (eval_x),
		.done   (eval_done),
		.sign   (eval_sign)
	);

	assign status.eval_done   = eval_done;
	assign status.same_sign   = (low_sign_q != SGN_ZERO) && (low_sign_q == high_sign_q);
	assign status.more_passes = (diff_w >= thr_w) && (pass_cnt_q != CBRF_PASS_LIMIT);
	assign status.mid_zero    = (mid_sign_q == SGN_ZERO);

	// Tolerance register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= CBRF_TOL_RESET;
		end else if (tolerance_wr_en) begin
			tol_q <= tolerance_wr_data;
		end
	end

	// Signs, pass counter and the result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_sign_q  <= SGN_ZERO;
			high_sign_q <= SGN_ZERO;
			mid_sign_q  <= SGN_ZERO;
			pass_cnt_q  <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= cmd.finish_no_root || cmd.finish_bracket || cmd.finish_mid_root;
			if (cmd.load) begin
				pass_cnt_q <= '0;
			end
			if (cmd.latch_sign) begin
				case (cmd.eval_sel)
					SEL_LOW:  low_sign_q  <= eval_sign;
					SEL_HIGH: high_sign_q <= eval_sign;
					SEL_MID: begin
						mid_sign_q <= eval_sign;
						pass_cnt_q <= pass_cnt_q + CBRF_CNT_W'(1);
					end
					default:  low_sign_q  <= eval_sign;
				endcase
			end
			if (cmd.apply_mid && !status.mid_zero && !opposite_w) begin
				low_sign_q <= mid_sign_q;
			end
		end
	end

	// Bracket ends and the midpoint under test.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			low_q  <= interval_low;
			high_q <= interval_high;
		end else if (cmd.apply_mid && !status.mid_zero) begin
			if (opposite_w) begin
				high_q <= mid_q;
			end else begin
				low_q <= mid_q;
			end
		end
		if (cmd.take_mid) begin
			mid_q <= bracket_mid_w;
		end
	end

	// Result registers, shown for one cycle with the strobe.
	always_ff @(posedge clk) begin
		if (cmd.finish_no_root) begin
			root_q    <= '0;
			count_q   <= '0;
			no_root_q <= 1'b1;
		end else if (cmd.finish_mid_root) begin
			root_q    <= mid_q;
			count_q   <= pass_cnt_q;
			no_root_q <= 1'b0;
		end else if (cmd.finish_bracket) begin
			root_q    <= bracket_mid_w;
			count_q   <= pass_cnt_q;
			no_root_q <= 1'b0;
		end
	end

	assign root            = root_q;
	assign iteration_count = count_q;
	assign no_root         = no_root_q;
	assign done            = done_q;

endmodule

// ===== hw/rtl/cbrf_ctrl.sv =====
module cbrf_ctrl
	import cbrf_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  cbrf_status_t status,
	output cbrf_cmd_t    cmd,
	output logic         busy
);

	typedef enum logic [9:0] {
		ST_IDLE   = 10'b0000000001,
		ST_L_LO   = 10'b0000000010,
		ST_W_LO   = 10'b0000000100,
		ST_L_HI   = 10'b0000001000,
		ST_W_HI   = 10'b0000010000,
		ST_ENDS   = 10'b0000100000,
		ST_CHECK  = 10'b0001000000,
		ST_L_MID  = 10'b0010000000,
		ST_W_MID  = 10'b0100000000,
		ST_UPDATE = 10'b1000000000
	} cbrf_state_t;

	cbrf_state_t state_q;
	cbrf_state_t state_d;

	assign busy = (state_q != ST_IDLE);

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_L_LO;
				end
			end
			ST_L_LO: begin
				cmd.eval_sel   = SEL_LOW;
				cmd.eval_start = 1'b1;
				state_d        = ST_W_LO;
			end
			ST_W_LO: begin
				cmd.eval_sel = SEL_LOW;
				if (status.eval_done) begin
					cmd.latch_sign = 1'b1;
					state_d        = ST_L_HI;
				end
			end
			ST_L_HI: begin
				cmd.eval_sel   = SEL_HIGH;
				cmd.eval_start = 1'b1;
				state_d        = ST_W_HI;
			end
			ST_W_HI: begin
				cmd.eval_sel = SEL_HIGH;
				if (status.eval_done) begin
					cmd.latch_sign = 1'b1;
					state_d        = ST_ENDS;
				end
			end
			ST_ENDS: begin
				if (status.same_sign) begin
					cmd.finish_no_root = 1'b1;
					state_d            = ST_IDLE;
				end else begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (status.more_passes) begin
					cmd.take_mid = 1'b1;
					state_d      = ST_L_MID;
				end else begin
					cmd.finish_bracket = 1'b1;
					state_d            = ST_IDLE;
				end
			end
			ST_L_MID: begin
				cmd.eval_sel   = SEL_MID;
				cmd.eval_start = 1'b1;
				state_d        = ST_W_MID;
			end
			ST_W_MID: begin
				cmd.eval_sel = SEL_MID;
				if (status.eval_done) begin
					cmd.latch_sign = 1'b1;
					state_d        = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				cmd.apply_mid = 1'b1;
				if (status.mid_zero) begin
					cmd.finish_mid_root = 1'b1;
					state_d             = ST_IDLE;
				end else begin
					state_d = ST_CHECK;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hw/rtl/cubic_bisection_root_finder.sv =====
// Channel   Direction  Transfer when                Signals
// input     in         start && !busy               interval_low, interval_high
// result    out        done (one cycle, no stall)   root, iteration_count, no_root
// config    in         tolerance_wr_en              tolerance_wr_data
//
// Each cubic evaluation runs on the shared X_WIDTH x X_WIDTH multiplier.
// An item evaluates both bracket ends, then one midpoint per pass; a bracket
// flagged as holding no root gives its result after the two end evaluations.
// Reset is asynchronous and active low; the tolerance returns to 33.
// One item is worked at a time; busy stays high until the result strobe.
// The receiver cannot stall: each result is shown for exactly one cycle.
module cubic_bisection_root_finder
	import cbrf_pkg::*;
#(
	parameter int X_WIDTH   = CBRF_X_WIDTH,
	parameter int FRAC_BITS = CBRF_FRAC_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic signed [X_WIDTH-1:0] interval_low,
	input  logic signed [X_WIDTH-1:0] interval_high,
	input  logic                      tolerance_wr_en,
	input  logic [CBRF_TOL_W-1:0]     tolerance_wr_data,
	output logic                      done,
	output logic signed [X_WIDTH-1:0] root,
	output logic [CBRF_CNT_W-1:0]     iteration_count,
	output logic                      no_root
);

	cbrf_cmd_t    cmd;
	cbrf_status_t status;

	// Sequencing of the search.
	cbrf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Bracket, evaluator and result registers.
	cbrf_datapath #(
		.X_WIDTH   (X_WIDTH),
		.FRAC_BITS (FRAC_BITS)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.status            (status),
		.interval_low      (interval_low),
		.interval_high     (interval_high),
		.tolerance_wr_en   (tolerance_wr_en),
		.tolerance_wr_data (tolerance_wr_data),
		.root              (root),
		.iteration_count   (iteration_count),
		.no_root           (no_root),
		.done              (done)
	);

`ifndef ASSERT_OFF
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	a_no_root_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && no_root) |-> (root == '0) && (iteration_count == '0))
		else $error("no-root result carries a root or a pass count");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("transfer accepted without going busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while the search is still running");
`endif

endmodule
